// ----- hw/rtl/slc_pkg.sv -----
// shared types, character codes and widths for the source line classifier
`default_nettype none

package slc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int TOTAL_WIDTH         = 32;
   localparam int CHAR_WIDTH          = 8;
   localparam int KIND_WIDTH          = 2;

   localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH     = 8'h2F;
   localparam logic [CHAR_WIDTH-1:0] CHAR_STAR      = 8'h2A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [CHAR_WIDTH-1:0] CHAR_QUOTE     = 8'h22;

   typedef enum logic [2:0] {
      SCAN_CODE,
      SCAN_SLASH,
      SCAN_STRING,
      SCAN_ESCAPE,
      SCAN_BLOCK,
      SCAN_BLOCK_STAR,
      SCAN_LINE_COMMENT,
      SCAN_STRING_ESCAPE
   } scan_state_type;

   // tab, newline, vertical tab, form feed, carriage return, space
   function automatic logic is_blank_char(input logic [CHAR_WIDTH-1:0] c);
      return c inside {[8'd9:8'd13], 8'd32};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/source_line_classifier.sv -----
// top level of the source line classifier: character scanner, line flags and line totals
`default_nettype none

// Source line classifier. Each request carries one source byte, or a line end
// when req_line_end is high (the byte is then ignored). The block scans for
// line comments, block comments that span lines, double-quoted strings and
// backslash escapes, and on every line end returns one response with the
// line's class (0 blank, 1 code only, 2 comment only, 3 code and comment)
// plus five running totals that saturate at 2^COUNT_WIDTH - 1 and are shown
// on 32-bit ports. Byte requests return nothing. Timing: one request per
// clock is taken, sustained, as long as the response side keeps up; a request
// is captured in the input register, the scanner and counter update run from
// there in a single pass, and a line end's response is then registered in the
// response slot that drives the ports once the slot is free. While a response
// waits under rsp_stall, byte requests keep flowing and only the next line
// end waits.
// The totals on the response ports are the counter registers themselves.
module source_line_classifier
   import slc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [CHAR_WIDTH-1:0]  req_char_code,
   input  wire logic                   req_line_end,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [KIND_WIDTH-1:0]  rsp_line_kind,
   output      logic [TOTAL_WIDTH-1:0] rsp_total_lines,
   output      logic [TOTAL_WIDTH-1:0] rsp_code_total,
   output      logic [TOTAL_WIDTH-1:0] rsp_comment_total,
   output      logic [TOTAL_WIDTH-1:0] rsp_mixed_total,
   output      logic [TOTAL_WIDTH-1:0] rsp_blank_total
);

   // saturating increment
   function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // input register
   logic                  in_valid_ff;
   logic [CHAR_WIDTH-1:0] in_char_ff;
   logic                  in_line_end_ff;

   // scanner state and per-line flags
   scan_state_type scan_state_ff, scan_state_in;
   logic           has_code_ff, has_code_in;
   logic           has_comment_ff, has_comment_in;

   // running totals
   logic [COUNT_WIDTH-1:0] lines_ff, code_ff, comment_ff, mixed_ff, blank_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [KIND_WIDTH-1:0] kind_ff, kind_in;

   logic out_free;
   logic proceed;
   logic close_line;
   logic line_code;

   // the response slot is free when empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // bytes never wait; a line end waits for the response slot
   assign proceed    = in_valid_ff && (!in_line_end_ff || out_free);
   assign close_line = proceed && in_line_end_ff;
   assign req_stall  = in_valid_ff && !proceed;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff     <= req_char_code;
         in_line_end_ff <= req_line_end;
      end
   end

   // scanner next state, one byte or one line end per pass
   always_comb begin
      scan_state_in  = scan_state_ff;
      has_code_in    = has_code_ff;
      has_comment_in = has_comment_ff;
      kind_in        = kind_ff;
      line_code      = has_code_ff;
      if (proceed && in_line_end_ff) begin
         // a slash left hanging at the line end is code
         if (scan_state_ff == SCAN_SLASH) begin
            line_code = 1'b1;
         end
         // only a block comment survives the line end, and a pending star is dropped
         if (scan_state_ff == SCAN_BLOCK || scan_state_ff == SCAN_BLOCK_STAR) begin
            scan_state_in = SCAN_BLOCK;
         end else begin
            scan_state_in = SCAN_CODE;
         end
         kind_in        = {has_comment_ff, line_code};
         has_code_in    = 1'b0;
         has_comment_in = 1'b0;
      end else if (proceed) begin
         case (scan_state_ff)
            SCAN_CODE, SCAN_SLASH: begin
               if (scan_state_ff == SCAN_SLASH && in_char_ff == CHAR_SLASH) begin
                  has_comment_in = 1'b1;
                  scan_state_in  = SCAN_LINE_COMMENT;
               end else if (scan_state_ff == SCAN_SLASH && in_char_ff == CHAR_STAR) begin
                  has_comment_in = 1'b1;
                  scan_state_in  = SCAN_BLOCK;
               end else begin
                  // lone slash counts as code, then the byte is scanned as code
                  if (scan_state_ff == SCAN_SLASH) begin
                     has_code_in = 1'b1;
                  end
                  if (in_char_ff == CHAR_SLASH) begin
                     scan_state_in = SCAN_SLASH;
                  end else if (in_char_ff == CHAR_BACKSLASH) begin
                     has_code_in   = 1'b1;
                     scan_state_in = SCAN_ESCAPE;
                  end else if (in_char_ff == CHAR_QUOTE) begin
                     has_code_in   = 1'b1;
                     scan_state_in = SCAN_STRING;
                  end else begin
                     scan_state_in = SCAN_CODE;
                     if (!is_blank_char(in_char_ff)) begin
                        has_code_in = 1'b1;
                     end
                  end
               end
            end
            SCAN_STRING: begin
               if (in_char_ff == CHAR_QUOTE) begin
                  scan_state_in = SCAN_CODE;
               end else if (in_char_ff == CHAR_BACKSLASH) begin
                  scan_state_in = SCAN_STRING_ESCAPE;
               end
            end
            SCAN_STRING_ESCAPE: begin
               scan_state_in = SCAN_STRING;
            end
            SCAN_ESCAPE: begin
               scan_state_in = SCAN_CODE;
            end
            SCAN_BLOCK, SCAN_BLOCK_STAR: begin
               if (!is_blank_char(in_char_ff)) begin
                  has_comment_in = 1'b1;
               end
               if (scan_state_ff == SCAN_BLOCK_STAR && in_char_ff == CHAR_SLASH) begin
                  scan_state_in = SCAN_CODE;
               end else if (in_char_ff == CHAR_STAR) begin
                  scan_state_in = SCAN_BLOCK_STAR;
               end else begin
                  scan_state_in = SCAN_BLOCK;
               end
            end
            SCAN_LINE_COMMENT: begin
               // rest of the line is ignored
            end
            default: begin
               scan_state_in = SCAN_CODE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_state_ff  <= SCAN_CODE;
         has_code_ff    <= 1'b0;
         has_comment_ff <= 1'b0;
      end else begin
         scan_state_ff  <= scan_state_in;
         has_code_ff    <= has_code_in;
         has_comment_ff <= has_comment_in;
      end
   end

   // totals move only when a line closes
   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff   <= '0;
         code_ff    <= '0;
         comment_ff <= '0;
         mixed_ff   <= '0;
         blank_ff   <= '0;
      end else if (close_line) begin
         lines_ff <= bump(lines_ff);
         if (line_code) begin
            code_ff <= bump(code_ff);
         end
         if (has_comment_ff) begin
            comment_ff <= bump(comment_ff);
         end
         if (line_code && has_comment_ff) begin
            mixed_ff <= bump(mixed_ff);
         end
         if (!line_code && !has_comment_ff) begin
            blank_ff <= bump(blank_ff);
         end
      end
   end

   // response slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (close_line) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_kind = kind_ff;

   // totals are shown on 32-bit ports: truncated or zero-extended
   generate
      if (COUNT_WIDTH >= TOTAL_WIDTH) begin : g_trunc
         assign rsp_total_lines   = lines_ff[TOTAL_WIDTH-1:0];
         assign rsp_code_total    = code_ff[TOTAL_WIDTH-1:0];
         assign rsp_comment_total = comment_ff[TOTAL_WIDTH-1:0];
         assign rsp_mixed_total   = mixed_ff[TOTAL_WIDTH-1:0];
         assign rsp_blank_total   = blank_ff[TOTAL_WIDTH-1:0];
      end else begin : g_extend
         assign rsp_total_lines   = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, lines_ff};
         assign rsp_code_total    = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, code_ff};
         assign rsp_comment_total = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, comment_ff};
         assign rsp_mixed_total   = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, mixed_ff};
         assign rsp_blank_total   = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, blank_ff};
      end
   endgenerate

   // a closed line leaves the flags clear for the next one
   a_flags_clear: assert property (@(posedge clock) disable iff (reset)
      close_line |=> !has_code_ff && !has_comment_ff)
      else $error("line flags not cleared after line end");

   // after a line end only plain scanning or an open block comment remains
   a_state_after_end: assert property (@(posedge clock) disable iff (reset)
      close_line |=> scan_state_ff == SCAN_CODE || scan_state_ff == SCAN_BLOCK)
      else $error("bad scanner state after line end");

   // the line total steps by one per closed line unless saturated
   a_lines_step: assert property (@(posedge clock) disable iff (reset)
      close_line |=> lines_ff == $past(lines_ff) + 1'b1 || &lines_ff)
      else $error("line total did not advance");

   // the line, blank and code totals shown with a waiting response must not move
   a_totals_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(lines_ff) && $stable(blank_ff)
                                    && $stable(code_ff))
      else $error("totals changed under a stalled response");

   // a response is raised only by a line end leaving the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(in_valid_ff && in_line_end_ff))
      else $error("response without a line end");

endmodule

`default_nettype wire

// ----- tb/sv/tb_source_line_classifier.sv -----
// self-checking testbench for the source line classifier: scripted lines, then random source text
module tb_source_line_classifier;
   import slc_pkg::*;

   localparam int COUNT_WIDTH     = COUNT_WIDTH_DEFAULT;
   localparam int CLOCK_PERIOD    = 12;
   localparam int RESET_CYCLES    = 4;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_CYCLES = 400000;

   // whitespace is tab through carriage return, plus space
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;

   // one line end's response, as the block should show it
   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [TOTAL_WIDTH-1:0] lines;
      logic [TOTAL_WIDTH-1:0] code;
      logic [TOTAL_WIDTH-1:0] comment;
      logic [TOTAL_WIDTH-1:0] mixed;
      logic [TOTAL_WIDTH-1:0] blank;
   } line_tally_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [CHAR_WIDTH-1:0]  req_char_code;
   logic                   req_line_end;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [KIND_WIDTH-1:0]  rsp_line_kind;
   logic [TOTAL_WIDTH-1:0] rsp_total_lines;
   logic [TOTAL_WIDTH-1:0] rsp_code_total;
   logic [TOTAL_WIDTH-1:0] rsp_comment_total;
   logic [TOTAL_WIDTH-1:0] rsp_mixed_total;
   logic [TOTAL_WIDTH-1:0] rsp_blank_total;

   // scanner state and line totals tracked on the testbench side
   scan_state_type         scan_q;
   logic                   line_code_q;
   logic                   line_comment_q;
   logic [COUNT_WIDTH-1:0] lines_q;
   logic [COUNT_WIDTH-1:0] code_q;
   logic [COUNT_WIDTH-1:0] comment_q;
   logic [COUNT_WIDTH-1:0] mixed_q;
   logic [COUNT_WIDTH-1:0] blank_q;

   line_tally_type expected_lines[$];
   int             requests_sent = 0;
   int             error_count   = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;

   source_line_classifier #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_kind    (rsp_line_kind),
      .rsp_total_lines  (rsp_total_lines),
      .rsp_code_total   (rsp_code_total),
      .rsp_comment_total(rsp_comment_total),
      .rsp_mixed_total  (rsp_mixed_total),
      .rsp_blank_total  (rsp_blank_total)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------
   // line classifier prediction
   // ------------------------------------------------------------------

   function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
      return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
   endfunction

   // totals stick at all ones
   function automatic logic [COUNT_WIDTH-1:0] bump_total(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic void clear_line_tracker();
      scan_q         = SCAN_CODE;
      line_code_q    = 1'b0;
      line_comment_q = 1'b0;
      lines_q        = '0;
      code_q         = '0;
      comment_q      = '0;
      mixed_q        = '0;
      blank_q        = '0;
   endfunction

   // a byte seen in plain code, outside strings and comments
   function automatic void take_code_byte(input logic [CHAR_WIDTH-1:0] c);
      if (c == CHAR_SLASH) begin
         // could open a comment, decided by the next byte
         scan_q = SCAN_SLASH;
      end else if (c == CHAR_BACKSLASH) begin
         line_code_q = 1'b1;
         scan_q      = SCAN_ESCAPE;
      end else if (c == CHAR_QUOTE) begin
         line_code_q = 1'b1;
         scan_q      = SCAN_STRING;
      end else if (!is_space(c)) begin
         line_code_q = 1'b1;
      end
   endfunction

   function automatic void take_byte(input logic [CHAR_WIDTH-1:0] c);
      case (scan_q)
         SCAN_CODE: take_code_byte(c);
         SCAN_SLASH: begin
            if (c == CHAR_SLASH) begin
               line_comment_q = 1'b1;
               scan_q         = SCAN_LINE_COMMENT;
            end else if (c == CHAR_STAR) begin
               line_comment_q = 1'b1;
               scan_q         = SCAN_BLOCK;
            end else begin
               // lone slash is code, and the byte after it is scanned as code
               line_code_q = 1'b1;
               scan_q      = SCAN_CODE;
               take_code_byte(c);
            end
         end
         SCAN_STRING: begin
            if (c == CHAR_QUOTE) begin
               scan_q = SCAN_CODE;
            end else if (c == CHAR_BACKSLASH) begin
               scan_q = SCAN_STRING_ESCAPE;
            end
         end
         SCAN_STRING_ESCAPE: scan_q = SCAN_STRING;
         SCAN_ESCAPE:        scan_q = SCAN_CODE;
         SCAN_BLOCK, SCAN_BLOCK_STAR: begin
            if (!is_space(c)) begin
               line_comment_q = 1'b1;
            end
            if (scan_q == SCAN_BLOCK_STAR && c == CHAR_SLASH) begin
               scan_q = SCAN_CODE;
            end else begin
               scan_q = (c == CHAR_STAR) ? SCAN_BLOCK_STAR : SCAN_BLOCK;
            end
         end
         default: ; // rest of a line comment is ignored
      endcase
   endfunction

   // update on one accepted request; a line end queues the expected response
   function automatic void classify_request(input logic [CHAR_WIDTH-1:0] c,
                                            input logic line_end);
      line_tally_type tally;
      if (!line_end) begin
         take_byte(c);
      end else begin
         // a slash still pending at the line end is code
         if (scan_q == SCAN_SLASH) begin
            line_code_q = 1'b1;
         end
         // only a block comment outlives the line, and a pending star is dropped
         scan_q = (scan_q == SCAN_BLOCK || scan_q == SCAN_BLOCK_STAR) ? SCAN_BLOCK : SCAN_CODE;
         lines_q = bump_total(lines_q);
         if (line_code_q) begin
            code_q = bump_total(code_q);
         end
         if (line_comment_q) begin
            comment_q = bump_total(comment_q);
         end
         if (line_code_q && line_comment_q) begin
            mixed_q = bump_total(mixed_q);
         end
         if (!line_code_q && !line_comment_q) begin
            blank_q = bump_total(blank_q);
         end
         tally.kind    = {line_comment_q, line_code_q};
         tally.lines   = TOTAL_WIDTH'(lines_q);
         tally.code    = TOTAL_WIDTH'(code_q);
         tally.comment = TOTAL_WIDTH'(comment_q);
         tally.mixed   = TOTAL_WIDTH'(mixed_q);
         tally.blank   = TOTAL_WIDTH'(blank_q);
         expected_lines.push_back(tally);
         line_code_q    = 1'b0;
         line_comment_q = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------

   function automatic void compare_field(input string name,
                                         input logic [TOTAL_WIDTH-1:0] want,
                                         input logic [TOTAL_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // every accepted response is matched against the oldest pending line
   always @(posedge clock) begin
      line_tally_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lines.size() == 0) begin
            $error("response with no line end pending");
            error_count++;
         end else begin
            want = expected_lines.pop_front();
            compare_field("line_kind", TOTAL_WIDTH'(want.kind), TOTAL_WIDTH'(rsp_line_kind));
            compare_field("total_lines", want.lines, rsp_total_lines);
            compare_field("code_total", want.code, rsp_code_total);
            compare_field("comment_total", want.comment, rsp_comment_total);
            compare_field("mixed_total", want.mixed, rsp_mixed_total);
            compare_field("blank_total", want.blank, rsp_blank_total);
         end
      end
   end

   // response side backpressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // ------------------------------------------------------------------
   // request driving
   // ------------------------------------------------------------------

   // entered and left at a falling edge; random gaps ahead of the request
   task automatic send_request(input logic [CHAR_WIDTH-1:0] char_code, input logic line_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= char_code;
      req_line_end  <= line_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      classify_request(char_code, line_end);
      requests_sent++;
      @(negedge clock);
   endtask

   // one whole line; the byte sent with the line end is junk the block ignores
   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_request(text[i], 1'b0);
      end
      send_request(CHAR_WIDTH'($urandom_range(255)), 1'b1);
   endtask

   function automatic logic [CHAR_WIDTH-1:0] random_space();
      int pick;
      pick = $urandom_range(5);
      return (pick == 5) ? CHAR_SPACE : CHAR_TAB + CHAR_WIDTH'(pick);
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] random_marker();
      case ($urandom_range(3))
         0:       return CHAR_SLASH;
         1:       return CHAR_STAR;
         2:       return CHAR_BACKSLASH;
         default: return CHAR_QUOTE;
      endcase
   endfunction

   // double-quoted string with escapes, left open now and then
   task automatic send_random_string();
      send_request(CHAR_QUOTE, 1'b0);
      repeat ($urandom_range(4)) begin
         if ($urandom_range(3) == 0) begin
            send_request(CHAR_BACKSLASH, 1'b0);
            send_request(CHAR_WIDTH'($urandom_range(255)), 1'b0);
         end else begin
            send_request(CHAR_WIDTH'($urandom_range(32, 126)), 1'b0);
         end
      end
      if ($urandom_range(3) != 0) begin
         send_request(CHAR_QUOTE, 1'b0);
      end
   endtask

   // a source-like line built from code, blanks, strings and comment markers
   task automatic send_random_line();
      int pieces;
      pieces = $urandom_range(5);
      for (int p = 0; p < pieces; p++) begin
         case ($urandom_range(7))
            0: repeat ($urandom_range(1, 4))
                  send_request(CHAR_WIDTH'($urandom_range(33, 126)), 1'b0);
            1: repeat ($urandom_range(1, 3)) send_request(random_space(), 1'b0);
            2: send_random_string();
            3: begin
               send_request(CHAR_SLASH, 1'b0);
               send_request(CHAR_SLASH, 1'b0);
               repeat ($urandom_range(3)) send_request(CHAR_WIDTH'($urandom_range(255)), 1'b0);
            end
            4: begin
               send_request(CHAR_SLASH, 1'b0);
               send_request(CHAR_STAR, 1'b0);
            end
            5: begin
               send_request(CHAR_STAR, 1'b0);
               send_request(CHAR_SLASH, 1'b0);
            end
            6:       send_request(random_marker(), 1'b0);
            default: send_request(CHAR_WIDTH'($urandom_range(255)), 1'b0);
         endcase
      end
      send_request(CHAR_WIDTH'($urandom_range(255)), 1'b1);
   endtask

   // raw bytes with line ends dropped in anywhere
   task automatic send_noise();
      repeat ($urandom_range(1, 8)) begin
         send_request(CHAR_WIDTH'($urandom_range(255)), $urandom_range(3) == 0);
      end
   endtask

   task automatic run_random_source(input int sender_pct, input int receiver_pct,
                                    input int stop_after);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      while (requests_sent < stop_after) begin
         if ($urandom_range(9) == 0) begin
            send_noise();
         end else begin
            send_random_line();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic test_scripted_lines();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_text("");           // empty line
      send_text("\t ");        // whitespace only
      send_text("\\\"/x");     // escaped quote outside a string, then a lone slash
      send_text("\"\\\"");     // escaped quote inside a string left open at the line end
      send_text("/*/");        // the star of the opener does not close it
      send_text("*");          // star pending at the line end
      send_text("/");          // ... and does not join with this slash
      send_text(" ");          // blank line inside the block comment
      send_text("*/a//");      // close, code, then a line comment
      send_text("/");          // lone slash at the line end is code
   endtask

   task automatic test_slow_receiver();
      run_random_source(17, 83, 390);
   endtask

   task automatic test_slow_sender();
      run_random_source(83, 17, 750);
   endtask

   task automatic test_full_rate();
      run_random_source(0, 0, 1100);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = '0;
      req_line_end  = 1'b0;
      clear_line_tracker();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_scripted_lines();
      test_slow_receiver();
      test_slow_sender();
      test_full_rate();

      // let the last line ends come out, then a quiet drain period
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_source_line_classifier: clean");
      end else begin
         $display("tb_source_line_classifier: errors");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(CLOCK_PERIOD * WATCHDOG_CYCLES);
      $display("tb_source_line_classifier: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/slc_pkg.sv
hw/rtl/source_line_classifier.sv
tb/sv/tb_source_line_classifier.sv
